// ===== sv/ftts_pkg.sv =====
// Shared types, constants and the quarter-wave sine table of the tone synthesiser.
package ftts_pkg;

    localparam int unsigned VOICES = 4;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned RATIO_BITS = 16;
    localparam int unsigned MAG_BITS = 15;
    localparam int unsigned RAISED_BITS = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CARRIER = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TREMOLO = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENVELOPE = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] CARRIER_RESET = 32'd35433480;
    localparam logic [CFG_DATA_BITS-1:0] TREMOLO_RESET = 32'd536871;
    localparam logic [CFG_DATA_BITS-1:0] ENVELOPE_RESET = 32'd11185;

    // Voice ratios 1/PHI^k in Q1.16 (ratio of voice 0 is one, 65536).
    function automatic logic [RATIO_BITS:0] phi_ratio(input logic [1:0] k);
        logic [RATIO_BITS:0] r;
        begin
            case (k)
                2'd0: r = 17'd65536;
                2'd1: r = 17'd40503;
                2'd2: r = 17'd25033;
                default: r = 17'd15471;
            endcase
            return r;
        end
    endfunction

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOICE,
        ST_MUL,
        ST_ADVANCE,
        ST_OUT
    } t_state;

    // Quarter-wave entry, exact integer polynomial; elaborated into constant logic.
    function automatic logic [MAG_BITS-1:0] quarter_entry(input int unsigned tbits,
                                                          input longint unsigned i);
        longint unsigned n, u, u2, t, s, v;
        begin
            n = 64'd1 << tbits;
            if (i > n) i = n;
            u = (i << 30) >> tbits;
            u2 = (u * u) >> 30;
            t = 64'd172272 - ((u2 * 64'd3864) >> 30);
            t = 64'd5026995 - ((u2 * t) >> 30);
            t = 64'd85569306 - ((u2 * t) >> 30);
            t = 64'd693598669 - ((u2 * t) >> 30);
            t = 64'd1686629713 - ((u2 * t) >> 30);
            s = (u * t) >> 30;
            v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) v = 64'd32767;
            return v[MAG_BITS-1:0];
        end
    endfunction

endpackage

// ===== sv/ftts_stream_if.sv =====
// Valid/ready channel carrying one payload value.
interface ftts_stream_if #(
    parameter int unsigned WIDTH = 1
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/four_voice_tremolo_tone_synth_unit.sv =====
// Top level: four-voice tremolo tone synthesiser with a shared serial multiplier.
// Each sample takes sixteen serial multiplications of 17 multiplier bits, three table
// reads per voice and one output step.
// One item in work at a time: a new input is taken only once the last sample is loaded.
// Reset (synchronous, active low) clears all phases, restores default increments.
module four_voice_tremolo_tone_synth_unit #(
    parameter int unsigned PHASE_BITS = 32,
    parameter int unsigned SINE_TABLE_BITS = 10,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ftts_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [ftts_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    ftts_stream_if.sink                           in_ch,
    ftts_stream_if.source                         out_ch
);
    localparam int unsigned MUL_A = 49;
    localparam int unsigned MUL_B = ftts_pkg::RAISED_BITS;
    localparam int unsigned P_BITS = MUL_A + MUL_B;
    localparam int unsigned SUM_BITS = 51;
    localparam int unsigned SHIFT = 37 + 15 - (SAMPLE_BITS - 1);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
    localparam logic [PHASE_BITS-1:0] EIGHTH = PHASE_BITS'(1) << (PHASE_BITS - 3);

    ftts_pkg::t_state r_state, n_state;
    logic [ftts_pkg::CFG_DATA_BITS-1:0] r_inc_c, r_inc_t, r_inc_e;
    logic [PHASE_BITS-1:0] r_cph [ftts_pkg::VOICES];
    logic [PHASE_BITS-1:0] r_eph [ftts_pkg::VOICES];
    logic [PHASE_BITS-1:0] r_tph;
    logic [1:0]            r_voice, n_voice;
    logic [2:0]            r_step, n_step;
    logic                  r_wait, n_wait;
    logic [1:0]            r_sel, n_sel;
    logic [PHASE_BITS-1:0] w_phase;
    logic [ftts_pkg::MAG_BITS-1:0]    w_mag;
    logic                             w_neg;
    logic [ftts_pkg::RAISED_BITS-1:0] w_raised;
    logic [ftts_pkg::MAG_BITS-1:0]    r_cm, n_cm;
    logic                             r_cneg, n_cneg;
    logic [ftts_pkg::RAISED_BITS-1:0] r_tr, n_tr, r_en, n_en;
    logic [P_BITS-1:0]     r_prod, n_prod;
    logic signed [SUM_BITS-1:0] r_sum, n_sum;
    logic                  w_start;
    logic [MUL_A-1:0]      w_ma;
    logic [MUL_B-1:0]      w_mb;
    logic                  w_done;
    logic [P_BITS-1:0]     w_product;
    logic [PHASE_BITS-1:0] w_step;
    logic                  r_ovalid, n_ovalid;
    logic [SAMPLE_BITS-1:0] r_out, n_out;
    logic signed [SUM_BITS-1:0] w_q;
    logic                  w_adv_c, w_adv_e, w_adv_t;

    // Sine lookup for the phase chosen by r_sel.
    always_comb begin
        case (r_sel)
            2'd0: w_phase = r_cph[r_voice];
            2'd1: begin
                case (r_voice)
                    2'd0: w_phase = r_tph - QUARTER;
                    2'd1: w_phase = r_tph - EIGHTH;
                    2'd2: w_phase = r_tph + EIGHTH;
                    default: w_phase = r_tph + QUARTER;
                endcase
            end
            default: w_phase = r_eph[r_voice] - QUARTER;
        endcase
    end

    ftts_sine #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
        .i_clk(i_clk), .i_phase(w_phase), .o_mag(w_mag), .o_neg(w_neg), .o_raised(w_raised)
    );

    ftts_serial_mul #(.A_BITS(MUL_A), .B_BITS(MUL_B)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_done), .o_product(w_product)
    );

    // Truncating divide toward zero of the voice sum.
    always_comb begin
        if (r_sum < 0)
            w_q = -((-r_sum) >>> SHIFT);
        else
            w_q = r_sum >>> SHIFT;
    end

    assign w_step = PHASE_BITS'(w_product >> 16);

    // Sequencer. Per voice: ST_VOICE steps 0..3 look up the three sines, ST_MUL step 0
    // multiplies carrier by tremolo, step 1 by envelope and accumulates.
    // ST_ADVANCE: per voice, step 0 carrier step, step 1 envelope step; tremolo after voice 3.
    always_comb begin
        n_state = r_state; n_voice = r_voice; n_step = r_step; n_wait = r_wait;
        n_sel = r_sel; n_cm = r_cm; n_cneg = r_cneg; n_tr = r_tr; n_en = r_en;
        n_prod = r_prod; n_sum = r_sum; n_ovalid = r_ovalid; n_out = r_out;
        w_start = 1'b0; w_ma = '0; w_mb = '0;
        w_adv_c = 1'b0; w_adv_e = 1'b0; w_adv_t = 1'b0;
        in_ch.ready = 1'b0;
        if (out_ch.ready) n_ovalid = 1'b0;
        unique case (r_state)
            ftts_pkg::ST_IDLE: begin
                // A waiting result sits in the output register and does not block input.
                in_ch.ready = 1'b1;
                if (in_ch.valid) begin
                    n_state = ftts_pkg::ST_VOICE;
                    n_voice = 2'd0; n_step = 3'd0; n_sel = 2'd0; n_sum = '0;
                end
            end
            ftts_pkg::ST_VOICE: begin
                // Table output registered.
                unique case (r_step)
                    3'd0: begin n_step = 3'd1; n_sel = 2'd1; end
                    3'd1: begin
                        n_cm = w_mag; n_cneg = w_neg;
                        n_step = 3'd2; n_sel = 2'd2;
                    end
                    3'd2: begin n_tr = w_raised; n_step = 3'd3; end
                    default: begin
                        n_en = w_raised;
                        n_state = ftts_pkg::ST_MUL; n_step = 3'd0; n_wait = 1'b0;
                    end
                endcase
            end
            ftts_pkg::ST_MUL: begin
                if (!r_wait) begin
                    w_start = 1'b1; n_wait = 1'b1;
                    if (r_step == 3'd0) begin
                        w_ma = MUL_A'(r_cm); w_mb = r_tr;
                    end else begin
                        w_ma = MUL_A'(r_prod); w_mb = r_en;
                    end
                end else if (w_done) begin
                    n_wait = 1'b0;
                    if (r_step == 3'd0) begin
                        n_prod = w_product; n_step = 3'd1;
                    end else begin
                        if (r_cneg) n_sum = r_sum - SUM_BITS'(w_product);
                        else n_sum = r_sum + SUM_BITS'(w_product);
                        n_step = 3'd0; n_sel = 2'd0;
                        if (r_voice == 2'd3) begin
                            n_state = ftts_pkg::ST_ADVANCE; n_voice = 2'd0;
                        end else begin
                            n_state = ftts_pkg::ST_VOICE; n_voice = r_voice + 2'd1;
                        end
                    end
                end
            end
            ftts_pkg::ST_ADVANCE: begin
                if (!r_wait) begin
                    w_start = 1'b1; n_wait = 1'b1;
                    w_ma = MUL_A'(r_step == 3'd0 ? r_inc_c : r_inc_e);
                    w_mb = ftts_pkg::phi_ratio(r_voice);
                end else if (w_done) begin
                    n_wait = 1'b0;
                    if (r_step == 3'd0) begin
                        w_adv_c = 1'b1; n_step = 3'd1;
                    end else begin
                        w_adv_e = 1'b1; n_step = 3'd0;
                        if (r_voice == 2'd3) begin
                            w_adv_t = 1'b1; n_state = ftts_pkg::ST_OUT;
                        end else begin
                            n_voice = r_voice + 2'd1;
                        end
                    end
                end
            end
            ftts_pkg::ST_OUT: begin
                // Load the sample once the output register is free or being emptied.
                if (!r_ovalid || out_ch.ready) begin
                    n_out = SAMPLE_BITS'(w_q);
                    n_ovalid = 1'b1;
                    n_state = ftts_pkg::ST_IDLE;
                end
            end
            default: n_state = ftts_pkg::ST_IDLE;
        endcase
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftts_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_wait <= 1'b0;
            r_voice <= '0;
            r_step <= '0;
            r_sel <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_wait <= n_wait;
            r_voice <= n_voice;
            r_step <= n_step;
            r_sel <= n_sel;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cm <= n_cm; r_cneg <= n_cneg; r_tr <= n_tr; r_en <= n_en;
        r_prod <= n_prod; r_sum <= n_sum; r_out <= n_out;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_c <= ftts_pkg::CARRIER_RESET;
            r_inc_t <= ftts_pkg::TREMOLO_RESET;
            r_inc_e <= ftts_pkg::ENVELOPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ftts_pkg::REG_CARRIER: r_inc_c <= i_cfg_data;
                ftts_pkg::REG_TREMOLO: r_inc_t <= i_cfg_data;
                ftts_pkg::REG_ENVELOPE: r_inc_e <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Phase state: cleared by reset or restart, stepped after each sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == ftts_pkg::ST_IDLE && in_ch.valid && in_ch.ready
                         && in_ch.data[0])) begin
            r_tph <= '0;
            for (int k = 0; k < ftts_pkg::VOICES; k++) begin
                r_cph[k] <= '0;
                r_eph[k] <= '0;
            end
        end else begin
            if (w_adv_c) r_cph[r_voice] <= r_cph[r_voice] + w_step;
            if (w_adv_e) r_eph[r_voice] <= r_eph[r_voice] + w_step;
            if (w_adv_t) r_tph <= r_tph + PHASE_BITS'(r_inc_t);
        end
    end
endmodule

// ===== sv/ftts_sine.sv =====
// Registered quarter-wave sine lookup returning raised and signed magnitude forms.
module ftts_sine #(
    parameter int unsigned PHASE_BITS = 32,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic [PHASE_BITS-1:0]                i_phase,
    output logic [ftts_pkg::MAG_BITS-1:0]        o_mag,
    output logic                                 o_neg,
    output logic [ftts_pkg::RAISED_BITS-1:0]     o_raised
);
    localparam int unsigned N = 1 << SINE_TABLE_BITS;
    localparam int unsigned IDX_BITS = SINE_TABLE_BITS + 1;

    logic [ftts_pkg::MAG_BITS-1:0] c_table [N+1];
    logic [SINE_TABLE_BITS+1:0]    w_top;
    logic [IDX_BITS-1:0]           w_idx;
    logic [ftts_pkg::MAG_BITS-1:0] r_mag;
    logic                          r_neg;

    // Constant table built at elaboration.
    for (genvar g = 0; g <= N; g++) begin : g_tab
        assign c_table[g] = ftts_pkg::quarter_entry(SINE_TABLE_BITS, longint'(g));
    end

    // Quadrant folding of the top phase bits.
    assign w_top = i_phase[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
    always_comb begin
        if (w_top[SINE_TABLE_BITS])
            w_idx = IDX_BITS'(N) - {1'b0, w_top[SINE_TABLE_BITS-1:0]};
        else
            w_idx = {1'b0, w_top[SINE_TABLE_BITS-1:0]};
    end

    // Registered table read.
    always_ff @(posedge i_clk) begin
        r_mag <= c_table[w_idx];
        r_neg <= w_top[SINE_TABLE_BITS+1];
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;
    assign o_raised = r_neg ? (17'd32768 - {2'b00, r_mag}) : (17'd32768 + {2'b00, r_mag});
endmodule

// ===== sv/ftts_serial_mul.sv =====
// Shift-and-add multiplier consuming one multiplier bit per cycle.
module ftts_serial_mul #(
    parameter int unsigned A_BITS = 32,
    parameter int unsigned B_BITS = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [A_BITS-1:0]       i_a,
    input  logic [B_BITS-1:0]       i_b,
    output logic                    o_done,
    output logic [A_BITS+B_BITS-1:0] o_product
);
    localparam int unsigned CNT_BITS = $clog2(B_BITS + 1);
    localparam int unsigned P_BITS = A_BITS + B_BITS;

    logic [P_BITS-1:0]   r_acc, n_acc;
    logic [P_BITS-1:0]   r_a, n_a;
    logic [B_BITS-1:0]   r_b, n_b;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;

    // One bit of the multiplier per cycle, low bit first.
    always_comb begin
        n_acc = r_acc; n_a = r_a; n_b = r_b;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a = P_BITS'(i_a);
            n_b = i_b;
            n_cnt = CNT_BITS'(B_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = r_a << 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_product = r_acc;
endmodule

// ===== sv/ftts_checker.sv =====
// Port-level checker for the tone synthesiser, bound to the top level.
module ftts_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [15:0] out_data
);
    // Only one item is in work: no input transfer straight after another.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("second input taken at once");

    // A new result never appears straight after an input transfer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");

    // Stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // Nothing out of reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind four_voice_tremolo_tone_synth_unit ftts_port_checker u_ftts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== verif/ftts_checker.sv =====
// Checker of the tone synthesiser: watches both channels, predicts each sample and compares.
module ftts_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_samples
);
    localparam logic [31:0] QUARTER = 32'h4000_0000;
    localparam logic [31:0] EIGHTH = 32'h2000_0000;

    logic [31:0] carrier_step;
    logic [31:0] tremolo_step;
    logic [31:0] envelope_step;
    logic [31:0] carrier_ph [4];
    logic [31:0] envelope_ph [4];
    logic [31:0] tremolo_ph;
    logic [15:0] sample_queue [$];
    logic [14:0] sine_rom [0:1024];

    // Build the quarter-wave table once.
    initial begin
        for (int i = 0; i <= 1024; i++) sine_rom[i] = ftts_pkg::quarter_entry(10, i);
    end

    // Ratio of voice k in Q1.16.
    function automatic logic [16:0] voice_ratio(input int k);
        case (k)
            0: return 17'd65536;
            1: return 17'd40503;
            2: return 17'd25033;
            default: return 17'd15471;
        endcase
    endfunction

    // Signed sine of a phase as Q1.15, from the top twelve phase bits.
    function automatic longint signed sine_of(input logic [31:0] ph);
        logic [1:0]  quad;
        logic [10:0] idx;
        begin
            quad = ph[31:30];
            idx = {1'b0, ph[29:20]};
            if (quad[0]) idx = 11'd1024 - idx;
            return quad[1] ? -longint'(sine_rom[idx]) : longint'(sine_rom[idx]);
        end
    endfunction

    // One sample from the current phases, then advance them.
    function automatic logic [15:0] next_sample(input logic restart);
        logic [31:0] offs [4];
        longint signed sum, cs, tr, en;
        logic [63:0] step;
        begin
            offs[0] = -QUARTER;
            offs[1] = -EIGHTH;
            offs[2] = EIGHTH;
            offs[3] = QUARTER;
            sum = 0;
            if (restart) begin
                tremolo_ph = '0;
                for (int k = 0; k < 4; k++) begin
                    carrier_ph[k] = '0;
                    envelope_ph[k] = '0;
                end
            end
            for (int k = 0; k < 4; k++) begin
                cs = sine_of(carrier_ph[k]);
                tr = sine_of(tremolo_ph + offs[k]) + 32768;
                en = sine_of(envelope_ph[k] - QUARTER) + 32768;
                sum += cs * tr * en;
            end
            sum = sum / (longint'(1) << 37);
            tremolo_ph += tremolo_step;
            for (int k = 0; k < 4; k++) begin
                step = (64'(carrier_step) * voice_ratio(k)) >> 16;
                carrier_ph[k] += step[31:0];
                step = (64'(envelope_step) * voice_ratio(k)) >> 16;
                envelope_ph[k] += step[31:0];
            end
            return sum[15:0];
        end
    endfunction

    // Print one line and count the mismatch.
    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("Mismatch: %s got %0d expected %0d", what, $signed(got), $signed(want));
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = sample_queue.size();

    // Track configuration, predict on each input transfer, compare on each output transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            carrier_step <= ftts_pkg::CARRIER_RESET;
            tremolo_step <= ftts_pkg::TREMOLO_RESET;
            envelope_step <= ftts_pkg::ENVELOPE_RESET;
            tremolo_ph = '0;
            for (int k = 0; k < 4; k++) begin
                carrier_ph[k] = '0;
                envelope_ph[k] = '0;
            end
            sample_queue.delete();
            o_samples <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ftts_pkg::REG_CARRIER: carrier_step <= i_cfg_data;
                    ftts_pkg::REG_TREMOLO: tremolo_step <= i_cfg_data;
                    ftts_pkg::REG_ENVELOPE: envelope_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) sample_queue.push_back(next_sample(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_samples <= o_samples + 1;
                if (sample_queue.size() == 0) begin
                    report("unexpected sample", i_out_data, 16'd0);
                end else begin
                    if (i_out_data !== sample_queue[0])
                        report("audio_out", i_out_data, sample_queue[0]);
                    void'(sample_queue.pop_front());
                end
            end
        end
    end
endmodule

// ===== verif/four_voice_tremolo_tone_synth_unit_test.sv =====
// Testbench top: clock, reset, configuration, restart stimulus and the verdict.
module four_voice_tremolo_tone_synth_unit_test;
    localparam int LATENCY = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          samples;
    int          send_idle;
    int          recv_idle;
    bit          hold_off;

    ftts_stream_if #(.WIDTH(1)) in_ch ();
    ftts_stream_if #(.WIDTH(16)) out_ch ();

    four_voice_tremolo_tone_synth_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    ftts_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_in_data(in_ch.data), .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_data(out_ch.data), .o_errors(errors), .o_pending(pending),
        .o_samples(samples)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Generous limit: about 650 samples plus stalls.
    initial begin
        #(8 * 3000000);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, with a long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) out_ch.ready <= 1'b0;
            else out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Write one register at a clock edge, then drop the enable.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one restart bit and wait for its transfer; valid stays up for the next item.
    task automatic send_item(input logic restart);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering, wait until every sample has arrived, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // A random step setting, often small so the waveform evolves visibly.
    function automatic logic [31:0] rand_step();
        case ($urandom_range(3))
            0: return $urandom_range(65535);
            1: return $urandom_range(32'h00FF_FFFF);
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset steps, restart both ways, then the step extremes.
        for (int i = 0; i < 8; i++) send_item(i == 3);
        drain();
        write_reg(ftts_pkg::REG_CARRIER, 32'hFFFF_FFFF);
        write_reg(ftts_pkg::REG_TREMOLO, 32'h0);
        write_reg(ftts_pkg::REG_ENVELOPE, 32'h8000_0000);
        write_reg(2'd3, 32'h1234_5678);
        for (int i = 0; i < 8; i++) send_item(i == 0);
        drain();
        write_reg(ftts_pkg::REG_CARRIER, 32'h0);
        write_reg(ftts_pkg::REG_TREMOLO, 32'hFFFF_FFFF);
        write_reg(ftts_pkg::REG_ENVELOPE, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_item(i == 5);
        drain();

        // Random phases with varying stall patterns and settings.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle = (ph < 2) ? 11 : (ph < 4) ? 59 : 0;
            recv_idle = (ph < 2) ? 59 : (ph < 4) ? 11 : 0;
            write_reg(ftts_pkg::REG_CARRIER, rand_step());
            write_reg(ftts_pkg::REG_TREMOLO, rand_step());
            write_reg(ftts_pkg::REG_ENVELOPE, rand_step());
            for (int i = 0; i < 100; i++) send_item($urandom_range(15) == 0);
            drain();
        end

        // Long receiver hold-off while items keep coming, then a full pause.
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++) send_item(i[0]);
        join
        drain();
        send_item(1'b0);
        drain();

        $display("Covered %0d samples: restarts, step extremes, unused index, stalls.",
                 samples);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
